// ----- src/bimodal_branch_predictor_macros.svh -----
// Assertion macros shared by the bimodal predictor RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef BIMODAL_BRANCH_PREDICTOR_MACROS_SVH
`define BIMODAL_BRANCH_PREDICTOR_MACROS_SVH

`ifndef SYNTH
`define BBP_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("implication check failed");
`define BBP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define BBP_ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define BBP_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- src/bbp_pkg.sv -----
// Package for the bimodal branch predictor: widths, counter codes and
// the saturating counter update. No dependencies.
`default_nettype none

package bbp_pkg;

  localparam int unsigned MAX_INDEX_BITS = 12;
  localparam int unsigned IDX_W          = MAX_INDEX_BITS;
  localparam int unsigned TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned COUNT_W        = 32;
  localparam int unsigned CTR_W          = 2;

  localparam logic [CFG_W-1:0] INDEX_BITS_RESET = CFG_W'(12);
  localparam logic [CFG_W-1:0] INDEX_BITS_MAX   = CFG_W'(MAX_INDEX_BITS);

  typedef logic [CTR_W-1:0] ctr_t;

  localparam ctr_t CTR_STRONG_TAKEN    = 2'b11;
  localparam ctr_t CTR_WEAK_TAKEN      = 2'b10;
  localparam ctr_t CTR_WEAK_NOT_TAKEN  = 2'b01;
  localparam ctr_t CTR_STRONG_NOT_TAKEN = 2'b00;

  // One step towards the resolved direction, saturating at both ends.
  function automatic ctr_t ctr_update(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_STRONG_TAKEN) res = ctr + ctr_t'(1);
    end else begin
      if (ctr != CTR_STRONG_NOT_TAKEN) res = ctr - ctr_t'(1);
    end
    return res;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- src/bimodal_branch_predictor.sv -----
// Path: an accepted item's entry is read into stage s1; its result is
// registered into the output stage when s1 advances. Throughput: one item
// per cycle unless the output stalls or a clearing pass runs; the counter
// table is a single-port-write, one-read memory, and a read that hits the
// entry being written is forwarded. Reset: the running counts clear at once;
// a clearing pass then sets all 4096 table entries to strongly taken, one per
// cycle, taking no item until done. Configuration writes are taken throughout.
`default_nettype none
`include "bimodal_branch_predictor_macros.svh"

module bimodal_branch_predictor
  import bbp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [31:0]        branch_address_i,
  input  wire logic               taken_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    predicted_taken_o,
  output logic                    mispredicted_o,
  output logic [COUNT_W-1:0]      branch_count_o,
  output logic [COUNT_W-1:0]      mispredict_count_o
);

  ctr_t mem_q [TABLE_DEPTH];

  logic [CFG_W-1:0]   index_bits_q;
  logic               clearing_q;
  logic [IDX_W-1:0]   clr_idx_q;

  logic               s1_valid_q;
  logic [IDX_W-1:0]   s1_idx_q;
  logic               s1_taken_q;
  ctr_t               rd_q;
  logic               fwd_q;
  ctr_t               fwd_ctr_q;

  logic               out_valid_q;
  logic               out_pred_q;
  logic               out_miss_q;
  logic [COUNT_W-1:0] branches_q, branches_d;
  logic [COUNT_W-1:0] mispred_q, mispred_d;

  logic               s1_adv;
  logic               in_acc;
  logic [CFG_W-1:0]   bits_clamped;
  logic [IDX_W-1:0]   idx_mask;
  logic [IDX_W-1:0]   in_idx;
  ctr_t               s1_ctr;
  ctr_t               new_ctr;
  logic               s1_pred;
  logic               s1_miss;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  ctr_t               mem_wdata;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = clearing_q | (s1_valid_q & ~s1_adv);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    bits_clamped = (index_bits_q > INDEX_BITS_MAX) ? INDEX_BITS_MAX : index_bits_q;
    idx_mask     = ~({IDX_W{1'b1}} << bits_clamped);
    in_idx       = branch_address_i[IDX_W-1:0] & idx_mask;
  end

  // The read of an item that follows its twin directly sees the old entry,
  // so the value written at that edge is carried alongside.
  always_comb begin
    s1_ctr     = fwd_q ? fwd_ctr_q : rd_q;
    s1_pred    = s1_ctr[CTR_W-1];
    s1_miss    = s1_pred ^ s1_taken_q;
    new_ctr    = ctr_update(s1_ctr, s1_taken_q);
    branches_d = sat_inc(branches_q);
    mispred_d  = s1_miss ? sat_inc(mispred_q) : mispred_q;
  end

  always_comb begin
    mem_we    = clearing_q | s1_adv;
    mem_waddr = clearing_q ? clr_idx_q : s1_idx_q;
    mem_wdata = clearing_q ? CTR_STRONG_TAKEN : new_ctr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (in_acc) rd_q <= mem_q[in_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= INDEX_BITS_RESET;
      clearing_q   <= 1'b1;
      clr_idx_q    <= '0;
    end else begin
      if (cfg_we_i) index_bits_q <= cfg_wdata_i;
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
        if (clr_idx_q == {IDX_W{1'b1}}) clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      branches_q  <= '0;
      mispred_q   <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv & (in_idx == s1_idx_q);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_q      <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        branches_q  <= branches_d;
        mispred_q   <= mispred_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q   <= in_idx;
      s1_taken_q <= taken_i;
      fwd_ctr_q  <= new_ctr;
    end
    if (s1_adv) begin
      out_pred_q <= s1_pred;
      out_miss_q <= s1_miss;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign predicted_taken_o  = out_pred_q;
  assign mispredicted_o     = out_miss_q;
  assign branch_count_o     = branches_q;
  assign mispredict_count_o = mispred_q;

  `BBP_ASSERT_IMPLIES(a_no_item_while_clearing, clk_i, rst_ni, clearing_q, !s1_valid_q)
  `BBP_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, in_acc, s1_valid_q)
  `BBP_ASSERT_IMPLIES(a_fwd_needs_item, clk_i, rst_ni, fwd_q, s1_valid_q)
  `BBP_ASSERT_IMPLIES(a_miss_le_branches, clk_i, rst_ni, 1'b1, mispred_q <= branches_q)
  `BBP_ASSERT_NEXT(a_result_counts, clk_i, rst_ni, s1_adv, branches_q != '0)

endmodule

`default_nettype wire
